@@ hdl/soa_pkg.sv @@
package soa_pkg;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_DEL = 2'd1;
    localparam logic [1:0] FUNC_GEN = 2'd2;
    localparam logic [1:0] FUNC_NOP = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOPATH = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [1:0] CFG_MAX    = 2'd0;
    localparam logic [1:0] CFG_MASK   = 2'd1;
    localparam logic [1:0] CFG_TRUNK  = 2'd2;
    localparam logic [1:0] CFG_SUBDIR = 2'd3;

    typedef struct packed {
        logic start;
        logic step;
        logic commit;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic path_ok;
        logic last;
        logic done;
    } t_stat;

endpackage

@@ hdl/soa_ctrl.sv @@
module soa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  soa_pkg::t_stat i_stat,
    output soa_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_stat.path_ok) n_state = S_SCAN;
                else                n_state = S_WR;
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) n_state = S_WR;
            end
            S_WR: begin
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLR;
        endcase
    end
endmodule

@@ hdl/soa_dp.sv @@
module soa_dp #(
    parameter int NUM_PATHS      = 16,
    parameter int SLOTS_PER_PATH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  soa_pkg::t_cmd  i_cmd,
    output soa_pkg::t_stat o_stat,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    input  logic [1:0]    i_func,
    input  logic [3:0]    i_path_index,
    input  logic [31:0]   i_subdir_id,
    output logic [1:0]    o_status,
    output logic [31:0]   o_out_subdir_id,
    output logic [63:0]   o_out_trunk_id
);
    localparam int SW    = $clog2(SLOTS_PER_PATH);
    localparam int PW    = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
    localparam int DEPTH = NUM_PATHS * (1 << SW);
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = 32 + 16 + 2;

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rd;
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_done;

    logic [15:0] r_max, r_mask;
    logic [63:0] r_trunk;
    logic [31:0] r_sdc;

    logic [1:0]  r_func;
    logic [PW-1:0] r_path;
    logic [31:0] r_sd;
    logic        r_ok;
    logic [SW:0] r_rd_idx;
    logic [SW-1:0] r_chk_idx;
    logic        r_chk;
    logic        r_found, r_empty, r_got;
    logic [SW-1:0] r_found_idx, r_empty_idx;
    logic [15:0] r_found_cnt;
    logic        r_found_free;
    logic [31:0] r_best;
    logic [1:0]  r_status;
    logic [31:0] r_osd;
    logic [63:0] r_otr;

    logic          path_ok;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] wr_data;
    logic          wr_en;
    logic          e_valid, e_free;
    logic [31:0]   e_sd;
    logic [15:0]   e_cnt, cnt_up, cnt_dn;

    assign path_ok = ({28'd0, i_path_index} < 32'(NUM_PATHS))
                     && r_mask[i_path_index];
    assign {e_valid, e_free, e_cnt, e_sd} = r_rd;
    assign rd_addr = AW'({r_path, r_rd_idx[SW-1:0]});
    assign cnt_up  = (r_found_cnt == 16'hFFFF) ? r_found_cnt : r_found_cnt + 16'd1;
    assign cnt_dn  = (r_found_cnt == 16'd0) ? r_found_cnt : r_found_cnt - 16'd1;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'({r_path, r_found_idx});
        wr_data = {1'b1, r_found_free, r_found_cnt, r_sd};
        if (i_cmd.clear) begin
            wr_en   = !r_clr_done;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (i_cmd.commit && r_ok) begin
            case (r_func)
                soa_pkg::FUNC_ADD: begin
                    wr_en = r_found || r_empty;
                    if (r_found)
                        wr_data = {1'b1, (cnt_up >= r_max) ? 1'b0 : r_found_free,
                                   cnt_up, r_sd};
                    else begin
                        wr_addr = AW'({r_path, r_empty_idx});
                        wr_data = {1'b1, (16'd1 < r_max), 16'd1, r_sd};
                    end
                end
                soa_pkg::FUNC_DEL: begin
                    wr_en   = r_found;
                    wr_data = {1'b1, (r_found_cnt >= r_max) | r_found_free,
                               cnt_dn, r_sd};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    assign o_stat.path_ok = r_ok && (r_func != soa_pkg::FUNC_NOP);
    assign o_stat.last    = r_chk && (r_chk_idx == SW'(SLOTS_PER_PATH - 1));
    assign o_stat.done    = r_clr_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
            r_max   <= 16'd256;
            r_mask  <= '0;
            r_trunk <= '0;
            r_sdc   <= '0;
        end else begin
            if (i_cmd.clear && !r_clr_done) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) r_clr_done <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    soa_pkg::CFG_MAX:    r_max   <= i_cfg_data[15:0];
                    soa_pkg::CFG_MASK:   r_mask  <= i_cfg_data[15:0];
                    soa_pkg::CFG_TRUNK:  r_trunk <= i_cfg_data;
                    soa_pkg::CFG_SUBDIR: r_sdc   <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit && r_ok && r_func == soa_pkg::FUNC_GEN) begin
                r_trunk <= r_trunk + 64'd1;
                if (!r_got) r_sdc <= r_sdc + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func   <= i_func;
            r_path   <= PW'(i_path_index);
            r_sd     <= i_subdir_id;
            r_ok     <= path_ok || (i_func == soa_pkg::FUNC_NOP);
            r_rd_idx <= '0;
            r_chk    <= 1'b0;
            r_found  <= 1'b0;
            r_empty  <= 1'b0;
            r_got    <= 1'b0;
        end else begin
            if (!r_rd_idx[SW] || r_rd_idx[SW-1:0] != '0) begin
                if (r_rd_idx != (SW+1)'(SLOTS_PER_PATH)) r_rd_idx <= r_rd_idx + (SW+1)'(1);
            end
            r_chk_idx <= r_rd_idx[SW-1:0];
            r_chk     <= (r_rd_idx != (SW+1)'(SLOTS_PER_PATH))
                         && (i_cmd.step || r_rd_idx == '0);
            if (r_chk) begin
                if (e_valid && e_sd == r_sd && !r_found) begin
                    r_found      <= 1'b1;
                    r_found_idx  <= r_chk_idx;
                    r_found_cnt  <= e_cnt;
                    r_found_free <= e_free;
                end
                if (!e_valid && !r_empty) begin
                    r_empty     <= 1'b1;
                    r_empty_idx <= r_chk_idx;
                end
                if (e_valid && e_free && (!r_got || e_sd < r_best)) begin
                    r_got  <= 1'b1;
                    r_best <= e_sd;
                end
            end
        end
        if (i_cmd.commit) begin
            r_status <= soa_pkg::ST_OK;
            r_osd    <= '0;
            r_otr    <= '0;
            if (!r_ok) r_status <= soa_pkg::ST_NOPATH;
            else if (r_func == soa_pkg::FUNC_ADD && !r_found && !r_empty)
                r_status <= soa_pkg::ST_FULL;
            else if (r_func == soa_pkg::FUNC_GEN) begin
                r_osd <= r_got ? r_best : r_sdc + 32'd1;
                r_otr <= r_trunk + 64'd1;
            end
        end
    end

    assign o_status        = r_status;
    assign o_out_subdir_id = r_osd;
    assign o_out_trunk_id  = r_otr;
endmodule

@@ hdl/subdir_occupancy_allocator.sv @@
// channel | valid   | ready   | payload
// request | i_valid | o_ready | i_func, i_path_index, i_subdir_id
// result  | o_valid | i_ready | o_status, o_out_subdir_id, o_out_trunk_id
// A request to a present path scans its slot table one entry a cycle through the
// memory read port before its result is offered; an absent path or the unused code
// skips the scan. The block returns to idle once the result is taken.
// After reset a clearing pass writes NUM_PATHS * (SLOTS_PER_PATH rounded up to a
// power of two) entries, one a cycle, before the first request is taken.
// One request at a time; a stalled result holds the block.
module subdir_occupancy_allocator #(
    parameter int NUM_PATHS      = 16,
    parameter int SLOTS_PER_PATH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [3:0]  i_path_index,
    input  logic [31:0] i_subdir_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_subdir_id,
    output logic [63:0] o_out_trunk_id
);
    soa_pkg::t_cmd  cmd;
    soa_pkg::t_stat stat;

    soa_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_stat(stat), .o_cmd(cmd)
    );

    soa_dp #(.NUM_PATHS(NUM_PATHS), .SLOTS_PER_PATH(SLOTS_PER_PATH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_func, .i_path_index, .i_subdir_id,
        .o_status, .o_out_subdir_id, .o_out_trunk_id
    );
endmodule
